/* rtl/apra_pkg.sv */
// Shared codes and widths for the aligned page-run allocator.
package apra_pkg;

  localparam int PN_W    = 52;
  localparam int CNT_W   = 13;
  localparam int ALIGN_W = 6;

  // request modes
  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_PAGES  = 2'd1;
  localparam logic [1:0] CFG_CONTIG = 2'd2;

endpackage

/* rtl/apra_bitmap.sv */
// Page used-mark memory with its clearing sweep.
module apra_bitmap
  import apra_pkg::*;
#(
  parameter int MAX_PAGES = 4096,
  parameter int IW        = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_req,
  output logic          clr_busy,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic          wr_data
);

  localparam logic [IW-1:0] LAST = IW'(MAX_PAGES - 1);

  logic          mem [MAX_PAGES];
  logic          clr_busy_r, clr_busy_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          rd_data_r;

  // sweep control: restart on request, stop after the last entry
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_req) begin
      clr_busy_nxt = 1'b1;
      clr_cnt_nxt  = '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == LAST) clr_busy_nxt = 1'b0;
      clr_cnt_nxt = clr_cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // single write port, shared by the sweep and the sequencer
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign clr_busy = clr_busy_r;
  assign rd_data  = rd_data_r;

endmodule

/* rtl/aligned_page_run_allocator_unit.sv */
// Top level of the aligned page-run allocator: sequencer, registers, result.
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+----------------------------
//  request  | start, busy, in_*                      | start high while busy low
//  result   | out_valid, out_*                       | one cycle with out_valid
//  config   | cfg_we, cfg_index, cfg_wdata           | any edge with cfg_we high
//
// Mode 0 checks each page of a run through the registered bitmap read (read, then
// check state) and marks the run page by page; mode 1 reads and checks each page it
// allocates, mode 2 one page; a bad or empty request is answered from setup.
// Reset, and a write of the base or page count, start a sweep over all MAX_PAGES
// entries that clears the bitmap; busy stays high until it ends. The receiver cannot
// stall: each result is shown for one cycle and the next request may follow.
module aligned_page_run_allocator_unit
  import apra_pkg::*;
#(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [CNT_W-1:0]   in_request_count,
  input  logic [ALIGN_W-1:0] in_align_log2,
  input  logic [PN_W-1:0]    in_page_number,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_granted_count,
  output logic [PN_W-1:0]    out_start_page,
  output logic [CNT_W-1:0]   out_free_pages,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [PN_W-1:0]    cfg_wdata
);

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PW = (IW > 13) ? IW + 2 : 15;
  localparam logic [20:0] MAXP = 21'(MAX_PAGES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_R0_RD  = 4'd2;
  localparam logic [3:0] S_R0_CHK = 4'd3;
  localparam logic [3:0] S_R0_MRK = 4'd4;
  localparam logic [3:0] S_R1_RD  = 4'd5;
  localparam logic [3:0] S_R1_CHK = 4'd6;
  localparam logic [3:0] S_FR_RD  = 4'd7;
  localparam logic [3:0] S_FR_CHK = 4'd8;

  // configuration
  logic [PN_W-1:0]  base_r;
  logic [CNT_W-1:0] pages_r;
  logic             contig_r;
  logic             reinit;

  // request and working registers
  logic [3:0]         state_r, state_nxt;
  logic [1:0]         mode_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ALIGN_W-1:0] align_r;
  logic [PN_W-1:0]    pn_r;
  logic [ALIGN_W-1:0] k_r, k_nxt;
  logic [PW-1:0]      off_r, off_nxt;
  logic [PW-1:0]      start_r, start_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;

  // result registers
  logic               valid_r, valid_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [CNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic [PN_W-1:0]    res_sp_r, res_sp_nxt;

  // bitmap connection
  logic rd_en, rd_data, wr_en, wr_data, clr_busy;

  // derived values
  logic [CNT_W-1:0]   n;
  logic [PW-1:0]      n_p;
  logic [ALIGN_W-1:0] alog_eff, k_set;
  logic [PN_W:0]      mask53, off53;
  logic [PN_W-1:0]    idx52;
  logic [PW-1:0]      stepm, v, new_start;
  logic               accept;

  assign reinit = cfg_we && (cfg_index inside {CFG_BASE, CFG_PAGES});
  assign busy   = (state_r != S_IDLE) || clr_busy || reinit;
  assign accept = start && !busy;

  // page count clipped to the bitmap depth
  assign n   = ({8'd0, pages_r} > MAXP) ? MAXP[CNT_W-1:0] : pages_r;
  assign n_p = PW'(n);

  // alignment setup: offset of the first boundary at or above the base
  assign alog_eff = (align_r < ALIGN_W'(PAGE_SHIFT)) ? ALIGN_W'(PAGE_SHIFT) : align_r;
  assign k_set    = alog_eff - ALIGN_W'(PAGE_SHIFT);
  assign mask53   = (k_set >= ALIGN_W'(PN_W + 1)) ? '1
                  : (((PN_W+1)'(1) << k_set) - (PN_W+1)'(1));
  assign off53    = ((PN_W+1)'(0) - {1'b0, base_r}) & mask53;
  assign idx52    = pn_r - base_r;

  // restart point after a used page (step at most one arena here)
  assign stepm     = (PW'(1) << k_r[3:0]) - PW'(1);
  assign v         = pos_r - off_r + PW'(1);
  assign new_start = ((v + stepm) & ~stepm) + off_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    off_nxt     = off_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r;
    i_nxt       = i_r;
    free_nxt    = free_r;
    valid_nxt   = 1'b0;
    res_st_nxt  = res_st_r;
    res_cnt_nxt = res_cnt_r;
    res_sp_nxt  = res_sp_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SETUP;
      end

      S_SETUP: begin
        k_nxt     = k_set;
        i_nxt     = '0;
        res_st_nxt  = ST_SHORT;
        res_cnt_nxt = '0;
        res_sp_nxt  = pn_r;
        case (mode_r)
          MODE_RUN: begin
            res_sp_nxt = '0;
            off_nxt    = off53[PW-1:0];
            start_nxt  = off53[PW-1:0];
            pos_nxt    = off53[PW-1:0];
            if (cnt_r == '0) begin
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (!contig_r) begin
              res_st_nxt = ST_OUTSIDE;
              valid_nxt  = 1'b1;
              state_nxt  = S_IDLE;
            end else if (off53 >= (PN_W+1)'(n)) begin
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_R0_RD;
            end
          end
          MODE_RANGE: begin
            pos_nxt = idx52[PW-1:0];
            if (cnt_r == '0) begin
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (idx52 >= PN_W'(n)) begin
              res_st_nxt = ST_OUTSIDE;
              valid_nxt  = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_R1_RD;
            end
          end
          MODE_FREE: begin
            pos_nxt = idx52[PW-1:0];
            if (idx52 >= PN_W'(n)) begin
              res_st_nxt = ST_OUTSIDE;
              valid_nxt  = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_FR_RD;
            end
          end
          default: begin
            res_sp_nxt = '0;
            valid_nxt  = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end

      // mode 0: check that the run still fits, then read the next mark
      S_R0_RD: begin
        if (start_r < n_p && (start_r + PW'(cnt_r)) <= n_p) begin
          rd_en     = 1'b1;
          state_nxt = S_R0_CHK;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_R0_CHK: begin
        if (rd_data) begin
          if (k_r >= ALIGN_W'(13)) begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            start_nxt = new_start;
            pos_nxt   = new_start;
            i_nxt     = '0;
            state_nxt = S_R0_RD;
          end
        end else if (i_r + CNT_W'(1) == cnt_r) begin
          pos_nxt   = start_r;
          i_nxt     = '0;
          state_nxt = S_R0_MRK;
        end else begin
          pos_nxt   = pos_r + PW'(1);
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_R0_RD;
        end
      end

      // mode 0: mark the run used, one page a cycle
      S_R0_MRK: begin
        wr_en    = 1'b1;
        wr_data  = 1'b1;
        free_nxt = free_r - CNT_W'(1);
        pos_nxt  = pos_r + PW'(1);
        i_nxt    = i_r + CNT_W'(1);
        if (i_r == cnt_r - CNT_W'(1)) begin
          res_st_nxt  = ST_OK;
          res_cnt_nxt = cnt_r;
          res_sp_nxt  = base_r + PN_W'(start_r);
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      // mode 1: walk upward while pages are free
      S_R1_RD: begin
        if (i_r < cnt_r && pos_r < n_p) begin
          rd_en     = 1'b1;
          state_nxt = S_R1_CHK;
        end else begin
          res_st_nxt  = (i_r == cnt_r) ? ST_OK : ST_SHORT;
          res_cnt_nxt = i_r;
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      S_R1_CHK: begin
        if (!rd_data) begin
          wr_en     = 1'b1;
          wr_data   = 1'b1;
          free_nxt  = free_r - CNT_W'(1);
          pos_nxt   = pos_r + PW'(1);
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_R1_RD;
        end else begin
          res_cnt_nxt = i_r;
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      // mode 2: free one page
      S_FR_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_FR_CHK;
      end

      S_FR_CHK: begin
        if (rd_data) begin
          wr_en       = 1'b1;
          free_nxt    = free_r + CNT_W'(1);
          res_st_nxt  = ST_OK;
          res_cnt_nxt = CNT_W'(1);
        end
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // arena re-created: free count follows the page count
    if (clr_busy) free_nxt = n;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pages_r  <= CNT_W'(4096);
      contig_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:   base_r   <= cfg_wdata;
        CFG_PAGES:  pages_r  <= cfg_wdata[CNT_W-1:0];
        CFG_CONTIG: contig_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      free_r  <= free_nxt;
    end
  end

  // request capture and working payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      cnt_r   <= in_request_count;
      align_r <= in_align_log2;
      pn_r    <= in_page_number;
    end
    k_r       <= k_nxt;
    off_r     <= off_nxt;
    start_r   <= start_nxt;
    pos_r     <= pos_nxt;
    i_r       <= i_nxt;
    res_st_r  <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_sp_r  <= res_sp_nxt;
  end

  apra_bitmap #(
    .MAX_PAGES (MAX_PAGES),
    .IW        (IW)
  ) u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_req  (reinit),
    .clr_busy (clr_busy),
    .rd_en    (rd_en),
    .rd_addr  (pos_r[IW-1:0]),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (pos_r[IW-1:0]),
    .wr_data  (wr_data)
  );

  assign out_valid         = valid_r;
  assign out_status        = res_st_r;
  assign out_granted_count = res_cnt_r;
  assign out_start_page    = res_sp_r;
  assign out_free_pages    = free_r;

endmodule

/* rtl/apra_checker.sv */
// Port-level checks for the allocator, bound to the top level.
module apra_checker
  import apra_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [1:0]       out_status,
  input logic [CNT_W-1:0] out_granted_count
);

  // a transfer in starts work at once
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result only closes a busy spell
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SHORT ||
                   out_status == ST_OUTSIDE))
    else $error("unknown status code");

  // a met request always grants pages
  a_ok_grants: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_granted_count != '0))
    else $error("status ok with nothing granted");

  a_outside_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OUTSIDE) |-> (out_granted_count == '0))
    else $error("pages granted outside the arena");

endmodule

bind aligned_page_run_allocator_unit apra_checker u_apra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_granted_count (out_granted_count)
);

/* verif/aligned_page_run_allocator_unit_tb.sv */
// Testbench for the aligned page-run allocator: directed and random requests.
module aligned_page_run_allocator_unit_tb;
  import apra_pkg::*;

  localparam int ARENA_MAX  = 4096;
  localparam int PG_SHIFT   = 12;
  localparam int CYCLE_CAP  = 6000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       status;
    logic [CNT_W-1:0] granted;
    logic [PN_W-1:0]  first_page;
    logic [CNT_W-1:0] free_left;
  } grant_rec_t;

  // Arena model: page marks, free count and registers, plus results awaited
  class page_arena_board;
    bit                page_taken[ARENA_MAX];
    int                free_cnt;
    logic [PN_W-1:0]   base_pn;
    logic [CNT_W-1:0]  pages_reg;
    bit                contig_on;
    grant_rec_t        awaited[$];
    int                errors;

    function new();
      base_pn = '0; pages_reg = 13'd4096; contig_on = 1'b1; errors = 0;
      rebuild();
    endfunction

    function int page_total();
      return (pages_reg > ARENA_MAX) ? ARENA_MAX : int'(pages_reg);
    endfunction

    function void rebuild();
      foreach (page_taken[i]) page_taken[i] = 1'b0;
      free_cnt = page_total();
    endfunction

    function void apply_config(logic [1:0] idx, logic [PN_W-1:0] val);
      case (idx)
        CFG_BASE:   begin base_pn = val; rebuild(); end
        CFG_PAGES:  begin pages_reg = val[CNT_W-1:0]; rebuild(); end
        CFG_CONTIG: contig_on = val[0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] st, int gc, logic [PN_W-1:0] sp);
      grant_rec_t r;
      r.status = st; r.granted = gc[CNT_W-1:0]; r.first_page = sp;
      r.free_left = free_cnt[CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    // Predict the result of one accepted transfer
    function void note_request(logic [1:0] md, logic [CNT_W-1:0] cnt,
                               logic [ALIGN_W-1:0] al, logic [PN_W-1:0] pn);
      longint unsigned n, k, step, rounded, off, pos, v, need;
      logic [PN_W-1:0] idx;
      bit broken, found;
      int got;
      n = page_total();
      need = cnt;
      idx = pn - base_pn;
      case (md)
        MODE_RUN: begin
          if (need == 0) push(ST_SHORT, 0, '0);
          else if (!contig_on) push(ST_OUTSIDE, 0, '0);
          else begin
            k = (al < PG_SHIFT) ? 0 : al - PG_SHIFT;
            step = 64'd1 << k;
            rounded = (base_pn + step - 1) & ~(step - 1);
            off = rounded - base_pn;
            found = 1'b0;
            if (off < n) begin
              pos = off;
              while (!found && pos < n && pos + need <= n) begin
                broken = 1'b0;
                for (longint unsigned i = 0; i < need && !broken; i++)
                  if (page_taken[pos + i]) begin
                    v = pos - off + i + 1;
                    pos = ((v + step - 1) & ~(step - 1)) + off;
                    broken = 1'b1;
                  end
                if (!broken) found = 1'b1;
              end
            end
            if (found) begin
              for (longint unsigned i = 0; i < need; i++) page_taken[pos + i] = 1'b1;
              free_cnt -= int'(need);
              push(ST_OK, int'(need), base_pn + pos[PN_W-1:0]);
            end else push(ST_SHORT, 0, '0);
          end
        end
        MODE_RANGE: begin
          if (need == 0) push(ST_SHORT, 0, pn);
          else if (idx >= n) push(ST_OUTSIDE, 0, pn);
          else begin
            got = 0;
            while (got < need && idx < n && !page_taken[idx]) begin
              page_taken[idx] = 1'b1; free_cnt--; got++; idx++;
            end
            push((got == need) ? ST_OK : ST_SHORT, got, pn);
          end
        end
        MODE_FREE: begin
          if (idx >= n) push(ST_OUTSIDE, 0, pn);
          else if (!page_taken[idx]) push(ST_SHORT, 0, pn);
          else begin
            page_taken[idx] = 1'b0; free_cnt++;
            push(ST_OK, 1, pn);
          end
        end
        default: push(ST_SHORT, 0, '0);
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [CNT_W-1:0] gc,
                               logic [PN_W-1:0] sp, logic [CNT_W-1:0] fp);
      grant_rec_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d granted %0d", st, gc);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st); errors++;
      end
      if (gc !== e.granted) begin
        $error("granted_count: expected %0d, got %0d", e.granted, gc); errors++;
      end
      if (sp !== e.first_page) begin
        $error("start_page: expected %h, got %h", e.first_page, sp); errors++;
      end
      if (fp !== e.free_left) begin
        $error("free_pages: expected %0d, got %0d", e.free_left, fp); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = '0;
  logic [CNT_W-1:0]   in_request_count = '0;
  logic [ALIGN_W-1:0] in_align_log2 = '0;
  logic [PN_W-1:0]    in_page_number = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_granted_count;
  logic [PN_W-1:0]    out_start_page;
  logic [CNT_W-1:0]   out_free_pages;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [PN_W-1:0]    cfg_wdata = '0;

  page_arena_board board = new();
  int unsigned cycles = 0;

  aligned_page_run_allocator_unit dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Result monitor and run-time cap
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      board.check_result(out_status, out_granted_count, out_start_page, out_free_pages);
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it; start is left high
  task automatic send_req(logic [1:0] md, logic [CNT_W-1:0] cnt,
                          logic [ALIGN_W-1:0] al, logic [PN_W-1:0] pn);
    start <= 1'b1;
    in_mode <= md; in_request_count <= cnt; in_align_log2 <= al; in_page_number <= pn;
    do @(posedge clk); while (busy);
    board.note_request(md, cnt, al, pn);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PN_W-1:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.apply_config(idx, val);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_req(logic [PN_W-1:0] base, int span);
    logic [1:0] md;
    logic [CNT_W-1:0] cnt;
    logic [ALIGN_W-1:0] al;
    logic [PN_W-1:0] pn;
    int r;
    r = $urandom_range(99);
    md = (r < 40) ? MODE_RUN : (r < 62) ? MODE_RANGE : (r < 95) ? MODE_FREE : MODE_UNUSED;
    r = $urandom_range(19);
    cnt = (r == 0) ? '0 : (r == 1) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 6));
    al = ($urandom_range(5) == 0) ? ALIGN_W'($urandom) : ALIGN_W'($urandom_range(10, 15));
    pn = ($urandom_range(7) == 0) ? PN_W'({$urandom, $urandom})
                                  : base + PN_W'($urandom_range(span + 2));
    send_req(md, cnt, al, pn);
  endtask

  initial begin
    logic [PN_W-1:0] base;
    int span;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: full arena after reset
    send_req(MODE_RUN, 0, 12, '0);
    send_req(MODE_RUN, 13'd4096, 0, '0);
    send_req(MODE_RUN, 1, 12, '0);
    send_req(MODE_FREE, 0, 0, 52'd5);
    send_req(MODE_FREE, 0, 0, 52'd5);
    send_req(MODE_FREE, 0, 0, 52'd4096);
    send_req(MODE_RANGE, 3, 0, 52'd5);
    send_req(MODE_RANGE, 0, 0, 52'd7);
    send_req(MODE_RANGE, 1, 0, {PN_W{1'b1}});
    send_req(MODE_UNUSED, {CNT_W{1'b1}}, {ALIGN_W{1'b1}}, {PN_W{1'b1}});
    send_req(MODE_RUN, {CNT_W{1'b1}}, 12, '0);
    send_req(MODE_FREE, 0, 0, 52'd100);
    send_req(MODE_FREE, 0, 0, 52'd101);
    send_req(MODE_RUN, 2, 13, '0);
    send_req(MODE_RUN, 1, 63, '0);
    // Ineligible arena
    write_reg(CFG_CONTIG, '0);
    send_req(MODE_RUN, 1, 12, '0);
    write_reg(CFG_CONTIG, 52'd1);
    // Arena wrapping past the top page number, oversized page count
    write_reg(CFG_BASE, {PN_W{1'b1}});
    write_reg(CFG_PAGES, {PN_W{1'b1}});
    send_req(MODE_RANGE, 3, 0, {PN_W{1'b1}});
    send_req(MODE_RUN, 2, 14, '0);
    // Empty arena
    write_reg(CFG_PAGES, '0);
    send_req(MODE_RUN, 1, 12, '0);
    send_req(MODE_RANGE, 1, 0, {PN_W{1'b1}});
    send_req(MODE_FREE, 0, 0, {PN_W{1'b1}});

    // Random phases under several arena settings
    for (int ph = 0; ph < 5; ph++) begin
      base = (ph == 1) ? 52'hFFFFFFFFFFFF0 : (ph == 3) ? '0 : PN_W'({$urandom, $urandom});
      span = (ph == 2) ? 1 : (ph == 3) ? 4096 : $urandom_range(16, 160);
      write_reg(CFG_BASE, base);
      write_reg(CFG_PAGES, (ph == 3) ? PN_W'(13'd8191) : PN_W'(span));
      write_reg(CFG_CONTIG, PN_W'(ph != 2));
      if (ph == 3) span = 200;
      for (int i = 0; i < 24; i++) begin
        random_req(base, span);
        if (i == 14) drain();
        else if (ph < 4 && $urandom_range(2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
